// ===== design/rcc_pkg.sv =====
// ---------------------------------------------------------------------------
// rcc_pkg: shared types and constants
// Color codes, register indexes and hue limits for the RGBC color classifier.
// ---------------------------------------------------------------------------
package rcc_pkg;

  typedef enum logic [2:0] {
    CODE_UNKNOWN = 3'd0,
    CODE_BLACK   = 3'd1,
    CODE_RED     = 3'd2,
    CODE_ORANGE  = 3'd3,
    CODE_YELLOW  = 3'd4,
    CODE_GREEN   = 3'd5,
    CODE_BLUE    = 3'd6
  } color_code_t;

  localparam logic [1:0] REG_WHITE_REF  = 2'd0;
  localparam logic [1:0] REG_DARK_LIMIT = 2'd1;
  localparam logic [1:0] REG_GREEN_SAT  = 2'd2;

  localparam logic [15:0] WHITE_RESET = 16'd0;
  localparam logic [7:0]  DARK_RESET  = 8'd21;
  localparam logic [7:0]  GSAT_RESET  = 8'd115;

  localparam logic [11:0] HUE_MAX = 12'd3599;

  // band edges in tenths of a degree
  localparam logic [19:0] K_DARK   = 20'd1380;
  localparam logic [19:0] K_RED_HI = 20'd3450;
  localparam logic [19:0] K_RED_LO = 20'd150;
  localparam logic [19:0] K_ORANGE = 20'd450;
  localparam logic [19:0] K_YELLOW = 20'd900;
  localparam logic [19:0] K_GREEN  = 20'd1600;
  localparam logic [19:0] K_BLUE   = 20'd2600;
  localparam logic [19:0] K_SIXTY  = 20'd600;
  localparam logic [19:0] K_120    = 20'd1200;
  localparam logic [19:0] K_240    = 20'd2400;
  localparam logic [19:0] K_360    = 20'd3600;

endpackage

// ===== design/rcc_div_pipe.sv =====
// ---------------------------------------------------------------------------
// rcc_div_pipe: pipelined restoring divider
// One quotient bit per stage, QW stages. Caller keeps num >> QW below den.
// ---------------------------------------------------------------------------
module rcc_div_pipe #(
  parameter int DW = 16,
  parameter int QW = 8
) (
  input  logic                clk,
  input  logic                en,
  input  logic [DW+QW-1:0]    num,
  input  logic [DW-1:0]       den,
  output logic [QW-1:0]       quo
);

  logic [DW-1:0] rem  [QW];
  logic [DW-1:0] dsr  [QW];
  logic [QW-1:0] low  [QW];
  logic [QW-1:0] qacc [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = num[DW+QW-1:QW];
      assign den_in = den;
      assign low_in = num[QW-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign den_in = dsr[i-1];
      assign low_in = low[i-1];
      assign q_in   = qacc[i-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dsr[i]  <= den_in;
        low[i]  <= {low_in[QW-2:0], 1'b0};
        qacc[i] <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo = qacc[QW-1];

endmodule

// ===== design/rgbc_color_classifier_unit.sv =====
// ---------------------------------------------------------------------------
// rgbc_color_classifier_unit: RGBC sample to HSV and color code
// Scales raw channels against white, converts to HSV, picks a hue band.
// ---------------------------------------------------------------------------
//  channel   | signals                          | content
//  ----------+----------------------------------+------------------------------
//  sample in | s_axis_tvalid/tready/tdata[63:0] | red, green, blue, clear raw
//  result    | m_axis_tvalid/tready/tdata[55:0] | r,g,b bytes, hue, sat, val, code
//  config    | cfg_valid/ready/index/data       | white_ref, dark limit, green sat
//
// One sample per cycle unless a stalled output holds s_axis_tready low.
// A sample passes the chain: channel divider (8 stages), HSV setup, then the
// hue divider (12 stages, one quotient bit each). No state between samples.
// Synchronous reset clears valid bits and restores register defaults.
// A stalled output freezes every stage at once; cfg_ready is always high.
// ---------------------------------------------------------------------------
module rgbc_color_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // red_raw, green_raw, blue_raw, clear_raw
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // red_byte, green_byte, blue_byte,
                                      // hue_tenths, sat_byte, val_byte, color_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NST   = 25;  // valid bits, stage 0 .. 24
  localparam int CH_QW = 8;
  localparam int H_QW  = 12;
  localparam int S_QW  = 8;
  localparam int SAT_DLY = H_QW - S_QW;

  // sideband carried past the hue divider
  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  mx;
    logic [2:0]  precode;
    logic        green_band;
    logic        d_zero;
    logic        mx_zero;
  } hsv_side_t;

  // ---- configuration ----
  logic [15:0] white_ref;
  logic [7:0]  dark_value_limit;
  logic [7:0]  green_sat_min;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_ref        <= rcc_pkg::WHITE_RESET;
      dark_value_limit <= rcc_pkg::DARK_RESET;
      green_sat_min    <= rcc_pkg::GSAT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rcc_pkg::REG_WHITE_REF:  white_ref        <= cfg_data;
        rcc_pkg::REG_DARK_LIMIT: dark_value_limit <= cfg_data[7:0];
        rcc_pkg::REG_GREEN_SAT:  green_sat_min    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control: whole pipe advances together ----
  logic           en;
  logic [NST-1:0] vld;

  assign en            = !vld[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], s_axis_tvalid};
    end
  end

  // ---- stage 0: capture sample ----
  logic [15:0] in_r, in_g, in_b, in_c;

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= s_axis_tdata[15:0];
      in_g <= s_axis_tdata[31:16];
      in_b <= s_axis_tdata[47:32];
      in_c <= s_axis_tdata[63:48];
    end
  end

  // ---- stage 1: channel * 255 ----
  logic [23:0] x_r, x_g, x_b;
  logic        zero1;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= {in_r, 8'h00} - {8'h00, in_r};
      x_g   <= {in_g, 8'h00} - {8'h00, in_g};
      x_b   <= {in_b, 8'h00} - {8'h00, in_b};
      zero1 <= (white_ref == '0) || (in_c == '0);
    end
  end

  // quotient saturates when x >= 256 * white
  logic [3:0] ch_flags1;
  assign ch_flags1 = {zero1, x_b[23:8] >= white_ref, x_g[23:8] >= white_ref,
                      x_r[23:8] >= white_ref};

  // ---- stages 2..9: channel dividers ----
  logic [7:0] q_r, q_g, q_b;

  rcc_div_pipe #(.DW(16), .QW(CH_QW)) u_div_r (
    .clk(clk), .en(en), .num(x_r), .den(white_ref), .quo(q_r));
  rcc_div_pipe #(.DW(16), .QW(CH_QW)) u_div_g (
    .clk(clk), .en(en), .num(x_g), .den(white_ref), .quo(q_g));
  rcc_div_pipe #(.DW(16), .QW(CH_QW)) u_div_b (
    .clk(clk), .en(en), .num(x_b), .den(white_ref), .quo(q_b));

  logic [3:0] ch_flags [CH_QW];

  always_ff @(posedge clk) begin
    if (en) begin
      ch_flags[0] <= ch_flags1;
      for (int i = 1; i < CH_QW; i++) ch_flags[i] <= ch_flags[i-1];
    end
  end

  // ---- stage 10: clamped bytes ----
  logic [3:0] fl9;
  logic [7:0] r10, g10, b10;
  assign fl9 = ch_flags[CH_QW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      r10 <= fl9[3] ? 8'd0 : (fl9[0] ? 8'hFF : q_r);
      g10 <= fl9[3] ? 8'd0 : (fl9[1] ? 8'hFF : q_g);
      b10 <= fl9[3] ? 8'd0 : (fl9[2] ? 8'hFF : q_b);
    end
  end

  // ---- stage 11: max, min, hue numerator ----
  logic [7:0]  mx10, mn10, d10;
  logic [19:0] num10;

  always_comb begin
    mx10 = r10;
    if (g10 > mx10) mx10 = g10;
    if (b10 > mx10) mx10 = b10;
    mn10 = r10;
    if (g10 < mn10) mn10 = g10;
    if (b10 < mn10) mn10 = b10;
    d10 = mx10 - mn10;
    // numerator is num / d = hue in tenths of a degree
    if (d10 == '0) begin
      num10 = '0;
    end else if (mx10 == r10) begin
      if (g10 >= b10) num10 = rcc_pkg::K_SIXTY * 20'(g10 - b10);
      else num10 = rcc_pkg::K_360 * 20'(d10) - rcc_pkg::K_SIXTY * 20'(b10 - g10);
    end else if (mx10 == g10) begin
      if (b10 >= r10) num10 = rcc_pkg::K_120 * 20'(d10) + rcc_pkg::K_SIXTY * 20'(b10 - r10);
      else num10 = rcc_pkg::K_120 * 20'(d10) - rcc_pkg::K_SIXTY * 20'(r10 - b10);
    end else begin
      if (r10 >= g10) num10 = rcc_pkg::K_240 * 20'(d10) + rcc_pkg::K_SIXTY * 20'(r10 - g10);
      else num10 = rcc_pkg::K_240 * 20'(d10) - rcc_pkg::K_SIXTY * 20'(g10 - r10);
    end
  end

  logic [7:0]  r11, g11, b11, mx11, d11;
  logic [19:0] num11;

  always_ff @(posedge clk) begin
    if (en) begin
      r11   <= r10;
      g11   <= g10;
      b11   <= b10;
      mx11  <= mx10;
      d11   <= d10;
      num11 <= num10;
    end
  end

  // ---- band decision on the exact rational hue ----
  logic [19:0] d11w;
  logic [2:0]  precode11;
  logic        gband11;
  assign d11w = 20'(d11);

  always_comb begin
    gband11 = 1'b0;
    if (mx11 < dark_value_limit && num11 > rcc_pkg::K_DARK * d11w)
      precode11 = rcc_pkg::CODE_BLACK;
    else if (num11 >= rcc_pkg::K_RED_HI * d11w || num11 <= rcc_pkg::K_RED_LO * d11w)
      precode11 = rcc_pkg::CODE_RED;
    else if (num11 <= rcc_pkg::K_ORANGE * d11w)
      precode11 = rcc_pkg::CODE_ORANGE;
    else if (num11 <= rcc_pkg::K_YELLOW * d11w)
      precode11 = rcc_pkg::CODE_YELLOW;
    else if (num11 <= rcc_pkg::K_GREEN * d11w) begin
      precode11 = rcc_pkg::CODE_GREEN;
      gband11   = 1'b1;
    end else if (num11 <= rcc_pkg::K_BLUE * d11w)
      precode11 = rcc_pkg::CODE_BLUE;
    else
      precode11 = rcc_pkg::CODE_UNKNOWN;
  end

  // ---- stages 12..23: hue and saturation dividers ----
  logic [11:0] q_hue;
  logic [7:0]  q_sat;
  logic [15:0] sat_num11;
  assign sat_num11 = {d11, 8'h00} - {8'h00, d11};

  rcc_div_pipe #(.DW(8), .QW(H_QW)) u_div_hue (
    .clk(clk), .en(en), .num(num11), .den(d11), .quo(q_hue));
  rcc_div_pipe #(.DW(8), .QW(S_QW)) u_div_sat (
    .clk(clk), .en(en), .num(sat_num11), .den(mx11), .quo(q_sat));

  hsv_side_t  side11;
  hsv_side_t  side [H_QW];
  logic [7:0] sat_d [SAT_DLY];

  assign side11 = '{r: r11, g: g11, b: b11, mx: mx11, precode: precode11,
                    green_band: gband11, d_zero: (d11 == '0), mx_zero: (mx11 == '0)};

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side11;
      for (int i = 1; i < H_QW; i++) side[i] <= side[i-1];
      sat_d[0] <= q_sat;
      for (int i = 1; i < SAT_DLY; i++) sat_d[i] <= sat_d[i-1];
    end
  end

  // ---- stage 24: output register ----
  hsv_side_t   s23;
  logic [11:0] hue23;
  logic [7:0]  sat23;
  logic [2:0]  code23;
  assign s23 = side[H_QW-1];

  always_comb begin
    if (s23.d_zero) hue23 = '0;
    else if (q_hue > rcc_pkg::HUE_MAX) hue23 = rcc_pkg::HUE_MAX;
    else hue23 = q_hue;
    sat23 = s23.mx_zero ? 8'd0 : sat_d[SAT_DLY-1];
    if (s23.green_band)
      code23 = (sat23 >= green_sat_min) ? rcc_pkg::CODE_GREEN : rcc_pkg::CODE_BLACK;
    else
      code23 = s23.precode;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {1'b0, code23, s23.mx, sat23, hue23, s23.b, s23.g, s23.r};
    end
  end

  // ---- checks ----
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[54:52] != 3'd7)
    else $error("color code out of range");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[35:24] <= rcc_pkg::HUE_MAX)
    else $error("hue out of range");

  a_val_is_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[51:44] >= m_axis_tdata[7:0] &&
                       m_axis_tdata[51:44] >= m_axis_tdata[15:8] &&
                       m_axis_tdata[51:44] >= m_axis_tdata[23:16]))
    else $error("value below a channel");

  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[43:36] == 8'd0) |-> m_axis_tdata[35:24] == 12'd0)
    else $error("gray sample with nonzero hue");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && !s_axis_tready ||
    $past(m_axis_tready) || m_axis_tready)
    else $error("output lost during stall");

endmodule
